@@ rtl/iqcpm_pkg.sv @@
// shared types and constants for the iq sample clip and power monitor
`default_nettype none

package iqcpm_pkg;

   localparam int SampleWidth   = 16;
   localparam int ScaledWidth   = 24;
   localparam int GainWidth     = 24;
   localparam int EnergyWidth   = 46;
   localparam int CountWidth    = 15;
   localparam int SinceWidth    = 32;
   localparam int TotalWidth    = 48;
   localparam int CsrIndexWidth = 8;
   localparam int CsrDataWidth  = 24;

   // register indexes on the csr port
   localparam logic [CsrIndexWidth-1:0] CSR_SAMPLE_FORMAT = 8'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_SCALE_GAIN    = 8'd1;

   // sample format codes
   localparam logic FMT_INT16 = 1'b0;
   localparam logic FMT_INT8  = 1'b1;

   localparam logic signed [SampleWidth-1:0] S16_MIN = -16'sd32768;
   localparam logic signed [SampleWidth-1:0] S16_MAX = 16'sd32767;
   localparam logic signed [SampleWidth-1:0] S8_MIN  = -16'sd128;
   localparam logic signed [SampleWidth-1:0] S8_MAX  = 16'sd127;

   localparam logic [GainWidth-1:0] GAIN_RESET = 24'h01_0000;

   typedef struct packed {
      logic signed [SampleWidth-1:0] i_sample;
      logic signed [SampleWidth-1:0] q_sample;
      logic                          last;
   } req_word_type;

   typedef struct packed {
      logic signed [ScaledWidth-1:0] i_scaled;
      logic signed [ScaledWidth-1:0] q_scaled;
      logic                          clipped;
      logic [SinceWidth-1:0]         since_clip;
      logic [TotalWidth-1:0]         clip_total;
      logic [TotalWidth-1:0]         sample_total;
      logic [EnergyWidth-1:0]        block_energy;
      logic [CountWidth-1:0]         block_count;
      logic                          block_done;
   } rsp_word_type;

endpackage

`default_nettype wire

@@ rtl/iq_sample_clip_and_power_monitor.sv @@
// top level: iq sample clip detection, gain scaling and block power monitor
// a req word passes through the input, product and result registers on its way to the rsp word
// throughput: one word per cycle while rsp_ready holds; a bubble in the pipe lets a new word in while rsp stalls
// the gain and square multipliers share the second stage with the format select and clip test, the counter and energy
// accumulator updates in the third
// reset (synchronous, active high) empties the pipe, clears all counters and the block sum,
// and sets 16-bit format with unity gain
`default_nettype none

module iq_sample_clip_and_power_monitor
   import iqcpm_pkg::*;
#(
   parameter int MAX_BLOCK = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // sample input
   input  wire logic                     req_valid,
   output      logic                     req_ready,
   input  wire req_word_type             req_word,
   // result output
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      rsp_word_type             rsp_word,
   // register writes
   input  wire logic                     csr_valid,
   output      logic                     csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_data
);

   // block sample count stops at the smaller of MAX_BLOCK and the 15-bit limit
   localparam int CapInt = (MAX_BLOCK < 32767) ? MAX_BLOCK : 32767;
   localparam logic [CountWidth-1:0] COUNT_CAP = CountWidth'(CapInt);
   localparam int ProdWidth = SampleWidth + GainWidth + 1;
   localparam int SqWidth   = 2 * SampleWidth - 1;

   // configuration
   logic                 fmt_ff;
   logic [GainWidth-1:0] gain_ff;

   // stage a: raw input word
   logic         a_valid_ff;
   req_word_type a_word_ff;

   // stage b: products and clip flag
   logic                        b_valid_ff;
   logic signed [ProdWidth-1:0] b_prod_i_ff, b_prod_q_ff;
   logic [SqWidth-1:0]          b_sq_i_ff, b_sq_q_ff;
   logic                        b_over_ff, b_last_ff;

   // stage c: result register
   logic         c_valid_ff;
   rsp_word_type c_word_ff;

   // running state
   logic [SinceWidth-1:0]  since_ff;
   logic [TotalWidth-1:0]  clip_tot_ff;
   logic [TotalWidth-1:0]  samp_tot_ff;
   logic [EnergyWidth-1:0] energy_ff;
   logic [CountWidth-1:0]  blk_cnt_ff;

   // stage enables, each stage moves when the next one has room
   logic c_en, b_en, a_en;

   assign c_en      = !c_valid_ff || rsp_ready;
   assign b_en      = !b_valid_ff || c_en;
   assign a_en      = !a_valid_ff || b_en;
   assign req_ready = a_en;
   assign csr_ready = 1'b1;
   assign rsp_valid = c_valid_ff;
   assign rsp_word  = c_word_ff;

   // ---------------- stage a -> b: format select, clip test, multiplies
   logic signed [SampleWidth-1:0] ip, qp, lo, hi;
   logic                          over_in;
   logic signed [ProdWidth-1:0]   prod_i_in, prod_q_in, gain_s;
   logic signed [2*SampleWidth-1:0] sq_i_full, sq_q_full;

   always_comb begin
      if (fmt_ff == FMT_INT8) begin
         // only the low byte counts in 8-bit format
         ip = SampleWidth'($signed(a_word_ff.i_sample[7:0]));
         qp = SampleWidth'($signed(a_word_ff.q_sample[7:0]));
         lo = S8_MIN;
         hi = S8_MAX;
      end else begin
         ip = a_word_ff.i_sample;
         qp = a_word_ff.q_sample;
         lo = S16_MIN;
         hi = S16_MAX;
      end
      over_in   = (ip == lo) || (ip == hi) || (qp == lo) || (qp == hi);
      gain_s    = $signed({{(ProdWidth-GainWidth){1'b0}}, gain_ff});
      prod_i_in = ProdWidth'(ip) * gain_s;
      prod_q_in = ProdWidth'(qp) * gain_s;
      sq_i_full = ip * ip;
      sq_q_full = qp * qp;
   end

   // ---------------- stage b -> c: floor shift, saturate, counters, energy
   logic signed [ProdWidth-17:0] sh_i, sh_q;
   logic signed [ScaledWidth-1:0] scl_i_in, scl_q_in;
   logic [SqWidth:0]              e_in;
   logic [EnergyWidth:0]          esum_wide;
   logic [EnergyWidth-1:0]        esum_in;
   logic [CountWidth-1:0]         cnt_in;
   logic [SinceWidth-1:0]         since_in;
   logic [TotalWidth-1:0]         clip_tot_in, samp_tot_in;
   rsp_word_type                  c_word_in;

   always_comb begin
      // arithmetic shift is a floor for both signs
      sh_i = b_prod_i_ff[ProdWidth-1:16];
      sh_q = b_prod_q_ff[ProdWidth-1:16];
      // saturate when the bits above the 24-bit range disagree with the sign
      if (sh_i[ProdWidth-17:ScaledWidth-1] != {(ProdWidth-16-ScaledWidth+1){sh_i[ProdWidth-17]}})
         scl_i_in = sh_i[ProdWidth-17] ? {1'b1, {(ScaledWidth-1){1'b0}}}
                                       : {1'b0, {(ScaledWidth-1){1'b1}}};
      else
         scl_i_in = sh_i[ScaledWidth-1:0];
      if (sh_q[ProdWidth-17:ScaledWidth-1] != {(ProdWidth-16-ScaledWidth+1){sh_q[ProdWidth-17]}})
         scl_q_in = sh_q[ProdWidth-17] ? {1'b1, {(ScaledWidth-1){1'b0}}}
                                       : {1'b0, {(ScaledWidth-1){1'b1}}};
      else
         scl_q_in = sh_q[ScaledWidth-1:0];

      // energy accumulate, stuck at full scale on overflow
      e_in      = {1'b0, b_sq_i_ff} + {1'b0, b_sq_q_ff};
      esum_wide = {1'b0, energy_ff} + (EnergyWidth+1)'(e_in);
      esum_in   = esum_wide[EnergyWidth] ? {EnergyWidth{1'b1}} : esum_wide[EnergyWidth-1:0];
      cnt_in    = (blk_cnt_ff < COUNT_CAP) ? blk_cnt_ff + 1'b1 : blk_cnt_ff;

      if (b_over_ff)
         since_in = '0;
      else if (since_ff != {SinceWidth{1'b1}})
         since_in = since_ff + 1'b1;
      else
         since_in = since_ff;
      clip_tot_in = clip_tot_ff + TotalWidth'(b_over_ff);
      samp_tot_in = samp_tot_ff + 1'b1;

      c_word_in.i_scaled     = scl_i_in;
      c_word_in.q_scaled     = scl_q_in;
      c_word_in.clipped      = b_over_ff;
      c_word_in.since_clip   = since_in;
      c_word_in.clip_total   = clip_tot_in;
      c_word_in.sample_total = samp_tot_in;
      c_word_in.block_energy = b_last_ff ? esum_in : '0;
      c_word_in.block_count  = b_last_ff ? cnt_in : '0;
      c_word_in.block_done   = b_last_ff;
   end

   // ---------------- configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff  <= FMT_INT16;
         gain_ff <= GAIN_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SAMPLE_FORMAT: fmt_ff  <= csr_data[0];
            CSR_SCALE_GAIN:    gain_ff <= csr_data[GainWidth-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline valids and running state
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff  <= 1'b0;
         b_valid_ff  <= 1'b0;
         c_valid_ff  <= 1'b0;
         since_ff    <= '0;
         clip_tot_ff <= '0;
         samp_tot_ff <= '0;
         energy_ff   <= '0;
         blk_cnt_ff  <= '0;
      end else begin
         if (a_en)
            a_valid_ff <= req_valid;
         if (b_en)
            b_valid_ff <= a_valid_ff;
         if (c_en)
            c_valid_ff <= b_valid_ff;
         // state advances once per word, as it enters the result register
         if (c_en && b_valid_ff) begin
            since_ff    <= since_in;
            clip_tot_ff <= clip_tot_in;
            samp_tot_ff <= samp_tot_in;
            energy_ff   <= b_last_ff ? '0 : esum_in;
            blk_cnt_ff  <= b_last_ff ? '0 : cnt_in;
         end
      end
   end

   // ---------------- payload registers
   always_ff @(posedge clock) begin
      if (a_en && req_valid)
         a_word_ff <= req_word;
      if (b_en && a_valid_ff) begin
         b_prod_i_ff <= prod_i_in;
         b_prod_q_ff <= prod_q_in;
         b_sq_i_ff   <= sq_i_full[SqWidth-1:0];
         b_sq_q_ff   <= sq_q_full[SqWidth-1:0];
         b_over_ff   <= over_in;
         b_last_ff   <= a_word_ff.last;
      end
      if (c_en && b_valid_ff)
         c_word_ff <= c_word_in;
   end

endmodule

`default_nettype wire

@@ tb/iq_sample_clip_and_power_monitor_test.sv @@
// testbench for the iq sample clip and power monitor: directed and random samples checked
`timescale 1ns / 1ps

module iq_sample_clip_and_power_monitor_test;
   import iqcpm_pkg::*;

   localparam int MAX_BLOCK_SAMPLES = 16384;
   // block sample count stops here (15-bit field)
   localparam longint BLOCK_CAP = (MAX_BLOCK_SAMPLES < 32767) ? MAX_BLOCK_SAMPLES : 32767;
   localparam longint ENERGY_MAX = 64'h0000_3FFF_FFFF_FFFF;
   localparam longint SINCE_MAX = 64'h0000_0000_FFFF_FFFF;
   localparam longint SCALED_MAX = 8388607;
   localparam longint SCALED_MIN = -8388608;
   localparam int LONG_HOLD = 300;
   localparam int CYCLE_LIMIT = 1_000_000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_word_type req_word;
   logic rsp_valid;
   logic rsp_ready;
   rsp_word_type rsp_word;
   logic csr_valid;
   logic csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0] csr_data;

   iq_sample_clip_and_power_monitor #(
      .MAX_BLOCK(MAX_BLOCK_SAMPLES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word(rsp_word),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // predictor copy of the register settings
   logic fmt_cfg;
   logic [GainWidth-1:0] gain_cfg;

   // predictor copy of the counters and the block accumulator
   longint since_clip_cnt;
   logic [TotalWidth-1:0] clip_total_cnt;
   logic [TotalWidth-1:0] sample_total_cnt;
   longint energy_acc;
   longint block_len;

   // result words still owed by the block, oldest first
   rsp_word_type expected_words[$];

   int mismatches = 0;
   int cycle_count = 0;
   bit req_idling = 0;
   bit rsp_idling = 0;
   bit long_hold_req = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit, far above the slowest correct run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic reset_model();
      fmt_cfg = FMT_INT16;
      gain_cfg = GAIN_RESET;
      since_clip_cnt = 0;
      clip_total_cnt = '0;
      sample_total_cnt = '0;
      energy_acc = 0;
      block_len = 0;
   endtask

   // part times the q8.16 gain, floor shift by 16, saturated to 24 bits
   function automatic logic signed [ScaledWidth-1:0] scale_part(logic signed [SampleWidth-1:0] v);
      longint s;
      longint g;
      longint r;
      s = v;
      g = gain_cfg;
      r = (s * g) >>> 16;
      if (r > SCALED_MAX) r = SCALED_MAX;
      else if (r < SCALED_MIN) r = SCALED_MIN;
      return r[ScaledWidth-1:0];
   endfunction

   // works out the result word for one accepted sample and advances the counters
   function automatic rsp_word_type predict_monitor_word(req_word_type w);
      rsp_word_type o;
      logic signed [SampleWidth-1:0] ip;
      logic signed [SampleWidth-1:0] qp;
      logic signed [SampleWidth-1:0] lo;
      logic signed [SampleWidth-1:0] hi;
      logic over;
      longint si;
      longint sq;
      if (fmt_cfg == FMT_INT8) begin
         // an 8-bit bus carries only the low byte of each part
         ip = {{8{w.i_sample[7]}}, w.i_sample[7:0]};
         qp = {{8{w.q_sample[7]}}, w.q_sample[7:0]};
         lo = S8_MIN;
         hi = S8_MAX;
      end else begin
         ip = w.i_sample;
         qp = w.q_sample;
         lo = S16_MIN;
         hi = S16_MAX;
      end
      over = (ip == lo) || (ip == hi) || (qp == lo) || (qp == hi);
      if (over) since_clip_cnt = 0;
      else if (since_clip_cnt < SINCE_MAX) since_clip_cnt++;
      clip_total_cnt = clip_total_cnt + over;
      sample_total_cnt = sample_total_cnt + 1'b1;
      si = ip;
      sq = qp;
      energy_acc = energy_acc + si * si + sq * sq;
      if (energy_acc > ENERGY_MAX) energy_acc = ENERGY_MAX;
      if (block_len < BLOCK_CAP) block_len++;
      o.i_scaled = scale_part(ip);
      o.q_scaled = scale_part(qp);
      o.clipped = over;
      o.since_clip = since_clip_cnt[SinceWidth-1:0];
      o.clip_total = clip_total_cnt;
      o.sample_total = sample_total_cnt;
      if (w.last) begin
         o.block_energy = energy_acc[EnergyWidth-1:0];
         o.block_count = block_len[CountWidth-1:0];
         o.block_done = 1'b1;
         energy_acc = 0;
         block_len = 0;
      end else begin
         // block fields read zero away from a block end
         o.block_energy = '0;
         o.block_count = '0;
         o.block_done = 1'b0;
      end
      return o;
   endfunction

   task automatic compare_field(string name, logic signed [63:0] want, logic signed [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   // every rsp word accepted is held against the oldest predicted word
   always @(posedge clock) begin : check_rsp
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $error("rsp word with no sample outstanding");
            mismatches++;
         end else begin
            want = expected_words.pop_front();
            compare_field("i_scaled", want.i_scaled, rsp_word.i_scaled);
            compare_field("q_scaled", want.q_scaled, rsp_word.q_scaled);
            compare_field("clipped", want.clipped, rsp_word.clipped);
            compare_field("since_clip", want.since_clip, rsp_word.since_clip);
            compare_field("clip_total", want.clip_total, rsp_word.clip_total);
            compare_field("sample_total", want.sample_total, rsp_word.sample_total);
            compare_field("block_energy", want.block_energy, rsp_word.block_energy);
            compare_field("block_count", want.block_count, rsp_word.block_count);
            compare_field("block_done", want.block_done, rsp_word.block_done);
         end
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap(bit idling);
      if (!idling || $urandom_range(0, 3) != 0) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // receiver side: random stalls, plus one long hold-off on request
   initial begin : drive_rsp_ready
      int stall;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall = LONG_HOLD;
         end else begin
            stall = pick_gap(rsp_idling);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // offer one sample word, keep it up until taken, then idle for the gap
   // (gap 0 leaves valid high for the next word)
   task automatic send_sample(input logic signed [SampleWidth-1:0] i_part,
                              input logic signed [SampleWidth-1:0] q_part,
                              input logic last_flag, input int gap);
      req_word_type w;
      w.i_sample = i_part;
      w.q_sample = q_part;
      w.last = last_flag;
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
      expected_words.push_back(predict_monitor_word(w));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drain();
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   // leaves csr_valid high so back-to-back writes need no drop
   task automatic write_csr(input logic [CsrIndexWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_SAMPLE_FORMAT) fmt_cfg = data[0];
      else if (idx == CSR_SCALE_GAIN) gain_cfg = data;
   endtask

   // registers only change with the pipe empty
   task automatic configure(input logic fmt, input logic [GainWidth-1:0] gain);
      wait_drain();
      write_csr(CSR_SAMPLE_FORMAT, {{(CsrDataWidth-1){1'b0}}, fmt});
      write_csr(CSR_SCALE_GAIN, gain);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [SampleWidth-1:0] random_part();
      case ($urandom_range(0, 15))
         0: return S16_MIN;
         1: return S16_MAX;
         2: return S8_MIN;
         3: return S8_MAX;
         // 8-bit extreme in the low byte under random upper bits
         4: return {8'($urandom), ($urandom_range(0, 1) ? 8'h7F : 8'h80)};
         5, 6: return 16'(int'($urandom_range(0, 600)) - 300);
         default: return 16'($urandom);
      endcase
   endfunction

   // reset settings: 16-bit format, unity gain; 16-bit clip edges on each part
   task automatic test_directed_extremes();
      send_sample(16'sd0, 16'sd0, 1'b0, 0);
      send_sample(S16_MAX, 16'sd0, 1'b0, 0);
      send_sample(S16_MIN, 16'sd0, 1'b0, 1);
      send_sample(16'sd0, S16_MAX, 1'b0, 2);
      send_sample(16'sd0, S16_MIN, 1'b0, 0);
      send_sample(16'sd1, -16'sd1, 1'b0, 0);
      send_sample(16'sd32766, -16'sd32767, 1'b1, 1);
   endtask

   // largest, zero and smallest gain: saturation and floor rounding
   task automatic test_gain_extremes();
      configure(FMT_INT16, 24'hFF_FFFF);
      send_sample(S16_MAX, S16_MIN, 1'b0, 0);
      send_sample(16'sd1, -16'sd1, 1'b0, 0);
      send_sample(-16'sd5, 16'sd3, 1'b1, 1);
      configure(FMT_INT16, 24'd0);
      send_sample(16'sd1234, -16'sd1234, 1'b0, 0);
      send_sample(S16_MAX, S16_MIN, 1'b1, 1);
      configure(FMT_INT16, 24'd1);
      send_sample(-16'sd1, 16'sd1, 1'b0, 0);
      send_sample(-16'sd32767, 16'sd32767, 1'b1, 1);
   endtask

   // 8-bit format: clip edges, and wide values cut to their low byte
   task automatic test_int8_format();
      configure(FMT_INT8, GAIN_RESET);
      send_sample(16'sd127, 16'sd0, 1'b0, 0);
      send_sample(-16'sd128, 16'sd5, 1'b0, 0);
      send_sample(16'sd126, -16'sd127, 1'b0, 1);
      send_sample(16'sh1280, 16'sd0, 1'b0, 0);
      send_sample(16'sh7F7F, 16'sh0102, 1'b0, 0);
      send_sample(16'shFF05, 16'sh80FF, 1'b0, 0);
      send_sample(16'sd3, 16'sh807F, 1'b1, 1);
   endtask

   // long hold-off on rsp while samples keep coming, then a drain and gapped traffic with random stalls
   task automatic test_backpressure();
      int k;
      configure(FMT_INT16, GAIN_RESET);
      req_idling = 0;
      rsp_idling = 0;
      long_hold_req = 1'b1;
      for (k = 0; k < 40; k++)
         send_sample(random_part(), random_part(), k == 39, (k == 39) ? 1 : 0);
      // sender waits for every result before going on
      wait_drain();
      req_idling = 1;
      rsp_idling = 1;
      for (k = 0; k < 40; k++)
         send_sample(random_part(), random_part(), $urandom_range(0, 7) == 0,
                     (k == 39) ? 1 : pick_gap(req_idling));
   endtask

   // one long block of full-scale samples for a large energy sum
   task automatic test_long_block();
      int k;
      configure(FMT_INT16, GAIN_RESET);
      req_idling = 0;
      rsp_idling = 0;
      for (k = 0; k < 60; k++)
         send_sample(S16_MIN, S16_MIN, k == 59, (k == 59) ? 1 : 0);
      // a short block right after shows the accumulator was cleared
      send_sample(16'sd10, -16'sd20, 1'b0, 0);
      send_sample(16'sd300, 16'sd400, 1'b1, 1);
   endtask

   // random samples across several format and gain settings
   task automatic test_random_traffic();
      int phase;
      int k;
      logic [GainWidth-1:0] gain;
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: gain = GAIN_RESET;
            1: gain = 24'hFF_FFFF;
            2: gain = 24'($urandom);
            3: gain = 24'd0;
            4: gain = 24'($urandom_range(1, 24'h03_0000));
            default: gain = 24'($urandom_range(1, 255));
         endcase
         configure(phase[0] ? FMT_INT8 : FMT_INT16, gain);
         // one phase runs flat out on both sides
         req_idling = (phase != 2);
         rsp_idling = (phase != 2);
         for (k = 0; k < 48; k++)
            send_sample(random_part(), random_part(), $urandom_range(0, 15) == 0,
                        (k == 47) ? 1 : pick_gap(req_idling));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      reset_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed_extremes();
      test_gain_extremes();
      test_int8_format();
      test_backpressure();
      test_long_block();
      test_random_traffic();

      // all words owed, then an idle spell for anything stray
      wait_drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
